// ===== hdl/taess_pkg.sv =====
package taess_pkg;

    localparam int EASE_STEPS_DEF = 20;
    localparam int STEP_W         = 6;
    localparam int EASE_W         = 12;
    localparam int HOLD_W         = 12;
    localparam int HOLD_SHIFT     = 22;
    localparam int EASE_SHIFT     = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int PTR_W          = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]        ANGLE_MAX = 8'd180;
    localparam logic [7:0]        HOME_RST  = 8'd90;
    localparam logic [HOLD_W-1:0] JUMP_HOLD = 12'd100;
    localparam logic [HOLD_W-1:0] MIN_HOLD  = 12'd10;
    localparam logic [HOLD_W-1:0] HOLD_MAX  = 12'd4095;

    localparam logic [1:0] CMD_MOVE_X  = 2'd0;
    localparam logic [1:0] CMD_MOVE_Y  = 2'd1;
    localparam logic [1:0] CMD_MOVE_XY = 2'd2;
    localparam logic [1:0] CMD_HOME    = 2'd3;

    localparam logic CFG_HOME_X = 1'b0;
    localparam logic CFG_HOME_Y = 1'b1;

    typedef struct packed {
        logic              wx;
        logic              wy;
        logic [7:0]        tx;
        logic [7:0]        ty;
        logic [HOLD_W-1:0] hold;
        logic              jump;
    } t_move;

    function automatic logic [EASE_W-1:0] ease_num(input logic [STEP_W-1:0] i,
                                                   input logic [STEP_W-1:0] n);
        logic [15:0] ii;
        logic [15:0] in_n;
        logic [15:0] nn;
        ii   = 16'(i) * 16'(i);
        in_n = 16'(i) * 16'(n);
        nn   = 16'(n) * 16'(n);
        if ({1'b0, i, 1'b0} < {2'b00, n}) begin
            return EASE_W'(ii << 1);
        end
        return EASE_W'((in_n << 2) - (ii << 1) - nn);
    endfunction

endpackage

// ===== hdl/two_axis_eased_servo_setpoints.sv =====
// Two-axis servo setpoint generator with quadratic ease-in-out.
//
// Command side: a queue write port. Drive cmd, goal_x, goal_y and
// duration_ms with push; the item is taken on a clock edge where push is
// high and full is low. Result side: a queue read port. While empty is low
// the oldest setpoint is on pos_x, pos_y, write_x, write_y, hold_ms and
// last_step; pop takes it. Home angles are written on the cfg channel
// (index 0 is X, index 1 is Y); cfg ready is always high.
//
// A command goes through a one-item front register and a two-entry command
// queue into the step sequencer, which, while the datapath is not frozen,
// issues one setpoint per cycle into a four-stage datapath (ease weight,
// delta product, reciprocal divide, output register). An eased move gives
// EASE_STEPS+1 setpoints (21 at the default), a zero duration jump gives
// one; the sequencer's step counter sets this. When pop stays low the whole
// datapath freezes; the front and the queue still take up to three more
// commands before full rises.
// Reset clears the queues, and sets both home angles and last positions
// to 90 degrees.
module two_axis_eased_servo_setpoints
    import taess_pkg::*;
#(
    parameter int EASE_STEPS = EASE_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_cmd,
    input  logic [9:0]        i_goal_x,
    input  logic [9:0]        i_goal_y,
    input  logic [15:0]       i_duration_ms,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        o_pos_x,
    output logic [7:0]        o_pos_y,
    output logic              o_write_x,
    output logic              o_write_y,
    output logic [HOLD_W-1:0] o_hold_ms,
    output logic              o_last_step
);

    logic  w_q_push;
    logic  w_q_full;
    logic  w_q_pop;
    logic  w_q_empty;
    t_move w_q_wdata;
    t_move w_q_rdata;

    taess_front #(
        .EASE_STEPS(EASE_STEPS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_goal_x     (i_goal_x),
        .i_goal_y     (i_goal_y),
        .i_duration_ms(i_duration_ms),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_q_push     (w_q_push),
        .o_q_data     (w_q_wdata),
        .i_q_full     (w_q_full)
    );

    taess_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_data (w_q_wdata),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_data (w_q_rdata),
        .o_empty(w_q_empty)
    );

    taess_back #(
        .EASE_STEPS(EASE_STEPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .o_q_pop    (w_q_pop),
        .i_q_data   (w_q_rdata),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_write_x  (o_write_x),
        .o_write_y  (o_write_y),
        .o_hold_ms  (o_hold_ms),
        .o_last_step(o_last_step)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_push && w_q_full))
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_pop && w_q_empty))
        else $error("command taken from an empty queue");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_pos_x <= ANGLE_MAX) && (o_pos_y <= ANGLE_MAX))
        else $error("setpoint beyond angle range");

    a_hold_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_hold_ms >= MIN_HOLD))
        else $error("hold time below minimum");

endmodule

// ===== hdl/taess_front.sv =====
module taess_front
    import taess_pkg::*;
#(
    parameter int EASE_STEPS = EASE_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_cmd,
    input  logic [9:0]  i_goal_x,
    input  logic [9:0]  i_goal_y,
    input  logic [15:0] i_duration_ms,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_q_push,
    output t_move       o_q_data,
    input  logic        i_q_full
);

    localparam longint unsigned HOLD_RECIP =
        ((64'd1 << HOLD_SHIFT) + longint'(EASE_STEPS) - 1) / longint'(EASE_STEPS);
    localparam int PROD_W = 16 + HOLD_SHIFT;

    logic              r_valid;
    logic              r_wx;
    logic              r_wy;
    logic [7:0]        r_tx;
    logic [7:0]        r_ty;
    logic [15:0]       r_dur;
    logic [7:0]        r_home_x;
    logic [7:0]        r_home_y;

    logic              w_accept;
    logic              n_wx;
    logic              n_wy;
    logic [7:0]        n_tx;
    logic [7:0]        n_ty;
    logic [7:0]        w_cx;
    logic [7:0]        w_cy;
    logic [PROD_W-1:0] w_prod;
    logic [15:0]       w_quot;
    logic [HOLD_W-1:0] w_hold;

    function automatic logic [7:0] clamp_angle(input logic [9:0] a);
        if (a[9]) begin
            return 8'd0;
        end
        if (a[8:0] > 9'(ANGLE_MAX)) begin
            return ANGLE_MAX;
        end
        return a[7:0];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_full      = r_valid && i_q_full;
    assign w_accept    = i_push && !o_full;
    assign o_q_push    = r_valid && !i_q_full;

    assign w_cx = clamp_angle(i_goal_x);
    assign w_cy = clamp_angle(i_goal_y);

    always_comb begin
        n_wx = 1'b1;
        n_wy = 1'b1;
        n_tx = w_cx;
        n_ty = w_cy;
        unique case (i_cmd)
            CMD_MOVE_X: begin
                n_wy = 1'b0;
            end
            CMD_MOVE_Y: begin
                n_wx = 1'b0;
            end
            CMD_MOVE_XY: begin
            end
            CMD_HOME: begin
                n_tx = (r_home_x > ANGLE_MAX) ? ANGLE_MAX : r_home_x;
                n_ty = (r_home_y > ANGLE_MAX) ? ANGLE_MAX : r_home_y;
            end
            default: begin
            end
        endcase
    end

    assign w_prod = PROD_W'(r_dur) * PROD_W'(HOLD_RECIP);
    assign w_quot = w_prod[HOLD_SHIFT +: 16];

    always_comb begin
        priority if (w_quot < 16'(MIN_HOLD)) begin
            w_hold = MIN_HOLD;
        end else if (w_quot > 16'(HOLD_MAX)) begin
            w_hold = HOLD_MAX;
        end else begin
            w_hold = w_quot[HOLD_W-1:0];
        end
    end

    assign o_q_data.wx   = r_wx;
    assign o_q_data.wy   = r_wy;
    assign o_q_data.tx   = r_tx;
    assign o_q_data.ty   = r_ty;
    assign o_q_data.jump = (r_dur == 16'd0);
    assign o_q_data.hold = (r_dur == 16'd0) ? JUMP_HOLD : w_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_home_x <= HOME_RST;
            r_home_y <= HOME_RST;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (o_q_push) begin
                r_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_HOME_X: r_home_x <= i_cfg_data;
                    CFG_HOME_Y: r_home_y <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_wx  <= n_wx;
            r_wy  <= n_wy;
            r_tx  <= n_tx;
            r_ty  <= n_ty;
            r_dur <= i_duration_ms;
        end
    end

endmodule

// ===== hdl/taess_queue.sv =====
module taess_queue
    import taess_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_move i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_move o_data,
    output logic  o_empty
);

    t_move            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;

    logic w_wr;
    logic w_rd;

    assign o_full  = (r_cnt == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== hdl/taess_back.sv =====
module taess_back
    import taess_pkg::*;
#(
    parameter int EASE_STEPS = EASE_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    input  t_move             i_q_data,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_pos_x,
    output logic [7:0]        o_pos_y,
    output logic              o_write_x,
    output logic              o_write_y,
    output logic [HOLD_W-1:0] o_hold_ms,
    output logic              o_last_step
);

    localparam longint unsigned DEN   = longint'(EASE_STEPS) * longint'(EASE_STEPS);
    localparam longint unsigned RECIP = ((64'd1 << EASE_SHIFT) + DEN - 1) / DEN;
    localparam int              MUL_W = 20 + 31;
    localparam logic [19:0]     BIAS  = 20'(DEN - 1);
    localparam logic [STEP_W-1:0] LAST_I = STEP_W'(EASE_STEPS);

    typedef struct packed {
        logic [7:0]        from_x;
        logic [7:0]        from_y;
        logic              wx;
        logic              wy;
        logic              last;
        logic [HOLD_W-1:0] hold;
    } t_step;

    logic              r_busy;
    logic [STEP_W-1:0] r_i;
    logic [7:0]        r_from_x;
    logic [7:0]        r_from_y;
    logic [7:0]        r_to_x;
    logic [7:0]        r_to_y;
    logic              r_wx;
    logic              r_wy;
    logic [HOLD_W-1:0] r_hold;

    logic               r_v0;
    t_step              r_s0;
    logic [EASE_W-1:0]  r_e;
    logic signed [8:0]  r_dx;
    logic signed [8:0]  r_dy;

    logic               r_v1;
    t_step              r_s1;
    logic signed [20:0] r_px;
    logic signed [20:0] r_py;

    logic               r_v2;
    t_step              r_s2;
    logic [7:0]         r_qx;
    logic [7:0]         r_qy;
    logic               r_nx;
    logic               r_ny;

    logic               r_ov;
    t_step              r_so;
    logic [7:0]         r_ox;
    logic [7:0]         r_oy;

    logic               w_en;
    logic               w_iss;
    logic               w_fin;
    logic               w_ld;
    logic signed [8:0]  w_dx;
    logic signed [8:0]  w_dy;
    logic signed [20:0] w_px;
    logic signed [20:0] w_py;
    logic [MUL_W-1:0]   w_mx;
    logic [MUL_W-1:0]   w_my;

    function automatic logic [19:0] mag_bias(input logic signed [20:0] p);
        logic [20:0] m;
        m = p[20] ? 21'(-p) : 21'(p);
        return m[19:0] + (p[20] ? BIAS : 20'd0);
    endfunction

    function automatic logic [7:0] apply(input logic [7:0] from, input logic [7:0] q,
                                         input logic neg);
        logic signed [9:0] v;
        v = neg ? ($signed({2'b00, from}) - $signed({2'b00, q}))
                : ($signed({2'b00, from}) + $signed({2'b00, q}));
        if (v < 10'sd0) begin
            return 8'd0;
        end
        if (v > $signed({2'b00, ANGLE_MAX})) begin
            return ANGLE_MAX;
        end
        return v[7:0];
    endfunction

    assign w_en    = !r_ov || i_pop;
    assign w_iss   = w_en && r_busy;
    assign w_fin   = w_iss && (r_i == LAST_I);
    assign w_ld    = !i_q_empty && (!r_busy || w_fin);
    assign o_q_pop = w_ld;

    assign w_dx = $signed({1'b0, r_to_x}) - $signed({1'b0, r_from_x});
    assign w_dy = $signed({1'b0, r_to_y}) - $signed({1'b0, r_from_y});
    assign w_px = 21'(r_dx) * 21'($signed({1'b0, r_e}));
    assign w_py = 21'(r_dy) * 21'($signed({1'b0, r_e}));
    assign w_mx = MUL_W'(mag_bias(r_px)) * MUL_W'(RECIP);
    assign w_my = MUL_W'(mag_bias(r_py)) * MUL_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_i      <= '0;
            r_from_x <= HOME_RST;
            r_from_y <= HOME_RST;
            r_to_x   <= HOME_RST;
            r_to_y   <= HOME_RST;
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (w_ld) begin
                r_busy   <= 1'b1;
                r_i      <= i_q_data.jump ? LAST_I : '0;
                r_from_x <= r_to_x;
                r_from_y <= r_to_y;
                r_to_x   <= i_q_data.wx ? i_q_data.tx : r_to_x;
                r_to_y   <= i_q_data.wy ? i_q_data.ty : r_to_y;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end else if (w_iss) begin
                r_i <= r_i + 1'b1;
            end
            if (w_en) begin
                r_v0 <= w_iss;
                r_v1 <= r_v0;
                r_v2 <= r_v1;
                r_ov <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_wx   <= i_q_data.wx;
            r_wy   <= i_q_data.wy;
            r_hold <= i_q_data.hold;
        end
        if (w_en) begin
            r_s0.from_x <= r_from_x;
            r_s0.from_y <= r_from_y;
            r_s0.wx     <= r_wx;
            r_s0.wy     <= r_wy;
            r_s0.last   <= (r_i == LAST_I);
            r_s0.hold   <= r_hold;
            r_e         <= ease_num(r_i, LAST_I);
            r_dx        <= w_dx;
            r_dy        <= w_dy;

            r_s1 <= r_s0;
            r_px <= w_px;
            r_py <= w_py;

            r_s2 <= r_s1;
            r_qx <= w_mx[EASE_SHIFT +: 8];
            r_qy <= w_my[EASE_SHIFT +: 8];
            r_nx <= r_px[20];
            r_ny <= r_py[20];

            r_so <= r_s2;
            r_ox <= apply(r_s2.from_x, r_qx, r_nx);
            r_oy <= apply(r_s2.from_y, r_qy, r_ny);
        end
    end

    assign o_empty     = !r_ov;
    assign o_pos_x     = r_ox;
    assign o_pos_y     = r_oy;
    assign o_write_x   = r_so.wx;
    assign o_write_y   = r_so.wy;
    assign o_hold_ms   = r_so.hold;
    assign o_last_step = r_so.last;

endmodule

// ===== bench/two_axis_eased_servo_setpoints_tb.sv =====
module two_axis_eased_servo_setpoints_tb;
    import taess_pkg::*;

    localparam int STEPS         = EASE_STEPS_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_MOVES   = 125;
    localparam int MAX_REPORTS   = 30;

    typedef struct {
        logic [7:0]        pos_x;
        logic [7:0]        pos_y;
        logic              wx;
        logic              wy;
        logic [HOLD_W-1:0] hold;
        logic              last;
    } t_setpoint;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic [1:0]        i_cmd;
    logic [9:0]        i_goal_x;
    logic [9:0]        i_goal_y;
    logic [15:0]       i_duration_ms;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_index;
    logic [7:0]        i_cfg_data;
    logic              empty;
    logic              pop;
    logic [7:0]        o_pos_x;
    logic [7:0]        o_pos_y;
    logic              o_write_x;
    logic              o_write_y;
    logic [HOLD_W-1:0] o_hold_ms;
    logic              o_last_step;

    t_setpoint   setpoint_q[$];
    logic [7:0]  cur_x;
    logic [7:0]  cur_y;
    logic [7:0]  home_x;
    logic [7:0]  home_y;
    logic        tx_gaps;
    logic        rx_gaps;
    int          rx_hold_off;
    int          errors;
    int          cycles;
    int          moves_sent;
    int          setpoints_checked;
    int          home_writes;

    two_axis_eased_servo_setpoints dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_goal_x     (i_goal_x),
        .i_goal_y     (i_goal_y),
        .i_duration_ms(i_duration_ms),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .empty        (empty),
        .pop          (pop),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_write_x    (o_write_x),
        .o_write_y    (o_write_y),
        .o_hold_ms    (o_hold_ms),
        .o_last_step  (o_last_step)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("two_axis_eased_servo_setpoints_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s", cycles, msg);
        end
    endtask

    function automatic logic [7:0] clamp_target(input logic signed [9:0] a);
        if (a < 0) begin
            return 8'd0;
        end
        if (a > 10'sd180) begin
            return ANGLE_MAX;
        end
        return a[7:0];
    endfunction

    function automatic logic [7:0] ease_point(input logic [7:0] src, input logic [7:0] dst,
                                              input int i);
        int e;
        int num;
        int q;
        if (2 * i < STEPS) begin
            e = 2 * i * i;
        end else begin
            e = -2 * i * i + 4 * i * STEPS - STEPS * STEPS;
        end
        num = int'(src) * STEPS * STEPS + (int'(dst) - int'(src)) * e;
        if (num < 0) begin
            num = 0;
        end
        q = num / (STEPS * STEPS);
        if (q > 180) begin
            q = 180;
        end
        return q[7:0];
    endfunction

    task automatic predict_move(input logic [1:0] cmd, input logic [9:0] tx,
                                input logic [9:0] ty, input logic [15:0] dur);
        logic [7:0] dst_x;
        logic [7:0] dst_y;
        int         hold;
        t_setpoint  sp;
        dst_x = cur_x;
        dst_y = cur_y;
        sp.wx = 1'b1;
        sp.wy = 1'b1;
        case (cmd)
            CMD_MOVE_X: begin
                dst_x = clamp_target(tx);
                sp.wy = 1'b0;
            end
            CMD_MOVE_Y: begin
                dst_y = clamp_target(ty);
                sp.wx = 1'b0;
            end
            CMD_MOVE_XY: begin
                dst_x = clamp_target(tx);
                dst_y = clamp_target(ty);
            end
            default: begin
                dst_x = (home_x > ANGLE_MAX) ? ANGLE_MAX : home_x;
                dst_y = (home_y > ANGLE_MAX) ? ANGLE_MAX : home_y;
            end
        endcase
        if (dur == 16'd0) begin
            sp.pos_x = dst_x;
            sp.pos_y = dst_y;
            sp.hold  = JUMP_HOLD;
            sp.last  = 1'b1;
            setpoint_q.push_back(sp);
        end else begin
            hold = int'(dur) / STEPS;
            if (hold < int'(MIN_HOLD)) begin
                hold = int'(MIN_HOLD);
            end
            if (hold > int'(HOLD_MAX)) begin
                hold = int'(HOLD_MAX);
            end
            for (int i = 0; i <= STEPS; i++) begin
                sp.pos_x = ease_point(cur_x, dst_x, i);
                sp.pos_y = ease_point(cur_y, dst_y, i);
                sp.hold  = hold[HOLD_W-1:0];
                sp.last  = (i == STEPS);
                setpoint_q.push_back(sp);
            end
        end
        cur_x = dst_x;
        cur_y = dst_y;
    endtask

    task automatic send_move(input logic [1:0] cmd, input logic [9:0] tx,
                             input logic [9:0] ty, input logic [15:0] dur);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            push = 1'b0;
        end
        @(negedge i_clk);
        push          = 1'b1;
        i_cmd         = cmd;
        i_goal_x      = tx;
        i_goal_y      = ty;
        i_duration_ms = dur;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        predict_move(cmd, tx, ty, dur);
        moves_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push = 1'b0;
        while (setpoint_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_home(input logic idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (idx == CFG_HOME_X) begin
            home_x = val;
        end else begin
            home_y = val;
        end
        home_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [9:0] rand_target();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return 10'($urandom_range(0, 180));
        end
        if (r == 7) begin
            return 10'($urandom_range(181, 511));
        end
        if (r == 8) begin
            return 10'(-$urandom_range(1, 512));
        end
        return 10'($urandom);
    endfunction

    function automatic logic [15:0] rand_duration();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            return 16'd0;
        end
        if (r < 6) begin
            return 16'($urandom_range(1, 400));
        end
        if (r < 8) begin
            return 16'($urandom_range(0, 8000));
        end
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] rand_home();
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom);
        end
        return 8'($urandom_range(0, 180));
    endfunction

    // Result side: random pop gaps, optional long hold-off, check each item.
    initial begin : rx_side
        int        n;
        t_setpoint want;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold_off > 0) begin
                n = rx_hold_off;
                rx_hold_off = 0;
                repeat (n) begin
                    @(negedge i_clk);
                    pop = 1'b0;
                end
            end
            n = rx_gaps ? $urandom_range(0, 3) : 0;
            repeat (n) begin
                @(negedge i_clk);
                pop = 1'b0;
            end
            @(negedge i_clk);
            pop = 1'b1;
            @(posedge i_clk);
            while (empty) begin
                @(posedge i_clk);
            end
            if (setpoint_q.size() == 0) begin
                report_mismatch($sformatf("unexpected setpoint x=%0d y=%0d",
                                          o_pos_x, o_pos_y));
            end else begin
                want = setpoint_q.pop_front();
                setpoints_checked++;
                if (o_pos_x !== want.pos_x) begin
                    report_mismatch($sformatf("pos_x got %0d want %0d", o_pos_x, want.pos_x));
                end
                if (o_pos_y !== want.pos_y) begin
                    report_mismatch($sformatf("pos_y got %0d want %0d", o_pos_y, want.pos_y));
                end
                if (o_write_x !== want.wx) begin
                    report_mismatch($sformatf("write_x got %b want %b", o_write_x, want.wx));
                end
                if (o_write_y !== want.wy) begin
                    report_mismatch($sformatf("write_y got %b want %b", o_write_y, want.wy));
                end
                if (o_hold_ms !== want.hold) begin
                    report_mismatch($sformatf("hold_ms got %0d want %0d", o_hold_ms, want.hold));
                end
                if (o_last_step !== want.last) begin
                    report_mismatch($sformatf("last_step got %b want %b",
                                              o_last_step, want.last));
                end
            end
        end
    end

    task automatic test_jumps_and_clamps();
        send_move(CMD_HOME, 10'h3FF, 10'h000, 16'd0);
        send_move(CMD_MOVE_X, 10'h200, 10'h1FF, 16'd0);
        send_move(CMD_MOVE_X, 10'h1FF, 10'h200, 16'd0);
        send_move(CMD_MOVE_Y, 10'h000, 10'h3FF, 16'd0);
        send_move(CMD_MOVE_Y, 10'h3FF, 10'd181, 16'd0);
        send_move(CMD_MOVE_XY, 10'd0, 10'd180, 16'd0);
        send_move(CMD_MOVE_XY, 10'd180, 10'd0, 16'd0);
        send_move(CMD_HOME, 10'h155, 10'h2AA, 16'd0);
        wait_drained();
    endtask

    task automatic test_eased_moves();
        send_move(CMD_MOVE_XY, 10'd0, 10'd180, 16'd1);
        send_move(CMD_MOVE_XY, 10'd180, 10'd0, 16'd200);
        send_move(CMD_MOVE_X, 10'd7, 10'd33, 16'd219);
        send_move(CMD_MOVE_Y, 10'd90, 10'd151, 16'd220);
        send_move(CMD_MOVE_XY, 10'h200, 10'h1FF, 16'hFFFF);
        send_move(CMD_HOME, 10'd0, 10'd0, 16'd1000);
        send_move(CMD_MOVE_X, 10'd91, 10'd0, 16'd3);
        send_move(CMD_MOVE_Y, 10'd0, 10'd89, 16'hAAAA);
        wait_drained();
    endtask

    task automatic test_home_registers();
        write_home(CFG_HOME_X, 8'd0);
        write_home(CFG_HOME_Y, 8'd180);
        send_move(CMD_HOME, 10'd50, 10'd50, 16'd0);
        send_move(CMD_MOVE_XY, 10'd180, 10'd0, 16'd0);
        send_move(CMD_HOME, 10'd50, 10'd50, 16'd400);
        wait_drained();
        write_home(CFG_HOME_X, 8'd255);
        write_home(CFG_HOME_Y, 8'd181);
        send_move(CMD_HOME, 10'd0, 10'd0, 16'd60);
        send_move(CMD_MOVE_XY, 10'd0, 10'd0, 16'd0);
        send_move(CMD_HOME, 10'd0, 10'd0, 16'd0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        rx_hold_off = 300;
        tx_gaps = 1'b0;
        for (int k = 0; k < 8; k++) begin
            send_move(2'($urandom), rand_target(), rand_target(),
                      16'($urandom_range(k % 2, 500)));
        end
        wait_drained();
    endtask

    task automatic test_random_moves();
        for (int phase = 0; phase < 4; phase++) begin
            write_home(CFG_HOME_X, rand_home());
            write_home(CFG_HOME_Y, rand_home());
            tx_gaps = !phase[0];
            rx_gaps = !phase[1];
            for (int k = 0; k < PHASE_MOVES; k++) begin
                send_move(2'($urandom), rand_target(), rand_target(), rand_duration());
            end
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_cmd         = CMD_MOVE_X;
        i_goal_x      = '0;
        i_goal_y      = '0;
        i_duration_ms = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_HOME_X;
        i_cfg_data    = '0;
        cur_x         = HOME_RST;
        cur_y         = HOME_RST;
        home_x        = HOME_RST;
        home_y        = HOME_RST;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        rx_hold_off   = 0;
        errors        = 0;
        moves_sent    = 0;
        setpoints_checked = 0;
        home_writes   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_jumps_and_clamps();
        test_eased_moves();
        test_home_registers();
        test_backpressure();
        test_random_moves();

        $display("covered %0d moves, %0d setpoints checked, %0d home writes",
                 moves_sent, setpoints_checked, home_writes);
        $display("jumps, eased moves, clamping, go-home, full-queue stall, random gaps");
        if (errors == 0) begin
            $display("two_axis_eased_servo_setpoints_tb: done, clean");
        end else begin
            $display("two_axis_eased_servo_setpoints_tb: done, errors");
        end
        $finish;
    end

endmodule
